// ----- rtl/vt4_pkg.sv -----
// shared types and constants for the 4x4 fixed-point vertex transform
package vt4_pkg;

	localparam int XLEN      = 32;
	localparam int MAT_W     = 64;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int NUM_COMP  = 4;
	localparam int PROD_W    = 2 * XLEN;
	localparam int ACC_W     = PROD_W + 2;

	localparam int DEF_DIM       = 4;
	localparam int DEF_FRAC_BITS = 16;

	// identity matrix in Q16.16
	localparam logic [MAT_W-1:0] CFG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	localparam logic CMD_MUL   = 1'b0;
	localparam logic CMD_MUL_T = 1'b1;

	typedef logic signed [XLEN-1:0] fx_t;

	typedef struct packed {
		fx_t  value;
		logic clip;
	} lane_res_t;

endpackage

// ----- rtl/vt4_lane.sv -----
// one output lane: products, adder tree, floor shift and saturation
module vt4_lane #(
	parameter int DIM       = vt4_pkg::DEF_DIM,
	parameter int FRAC_BITS = vt4_pkg::DEF_FRAC_BITS
) (
	input  logic              clk,
	input  vt4_pkg::fx_t      mat_s1 [vt4_pkg::NUM_COMP],
	input  vt4_pkg::fx_t      vec_s1 [vt4_pkg::NUM_COMP],
	output vt4_pkg::lane_res_t res_s4
);
	import vt4_pkg::*;

	logic signed [PROD_W-1:0] prod_s2 [DIM];
	logic signed [ACC_W-1:0]  term    [NUM_COMP];
	logic signed [ACC_W-1:0]  pair_s3 [2];
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  shifted;
	logic                     ovf;

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIM; k++) begin
			prod_s2[k] <= PROD_W'(mat_s1[k]) * PROD_W'(vec_s1[k]);
		end
	end

	for (genvar k = 0; k < NUM_COMP; k++) begin : g_term
		if (k < DIM) begin : g_used
			assign term[k] = ACC_W'(prod_s2[k]);
		end else begin : g_pad
			assign term[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		pair_s3[0] <= term[0] + term[1];
		pair_s3[1] <= term[2] + term[3];
	end

	// exact sum, then floor shift; out of range when the top bits are not all sign
	always_comb begin
		sum     = pair_s3[0] + pair_s3[1];
		shifted = sum >>> FRAC_BITS;
		ovf     = !((&shifted[ACC_W-1:XLEN-1]) || !(|shifted[ACC_W-1:XLEN-1]));
	end

	always_ff @(posedge clk) begin
		if (ovf) begin
			res_s4.value <= shifted[ACC_W-1] ? {1'b1, {(XLEN-1){1'b0}}}
			                                 : {1'b0, {(XLEN-1){1'b1}}};
		end else begin
			res_s4.value <= shifted[XLEN-1:0];
		end
		res_s4.clip <= ovf;
	end

endmodule

// ----- rtl/vt4_merge.sv -----
// merge stage: collects lane results into one output word and the clip flag
module vt4_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s4,
	input  vt4_pkg::lane_res_t res_s4 [vt4_pkg::NUM_COMP],
	output logic               done,
	output vt4_pkg::fx_t       out_x,
	output vt4_pkg::fx_t       out_y,
	output vt4_pkg::fx_t       out_z,
	output vt4_pkg::fx_t       out_w,
	output logic               clipped
);
	import vt4_pkg::*;

	logic any_clip;

	always_comb begin
		any_clip = 1'b0;
		for (int i = 0; i < NUM_COMP; i++) begin
			any_clip = any_clip | res_s4[i].clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		out_x   <= res_s4[0].value;
		out_y   <= res_s4[1].value;
		out_z   <= res_s4[2].value;
		out_w   <= res_s4[3].value;
		clipped <= any_clip;
	end

endmodule

// ----- rtl/vertex_transform_4x4_core.sv -----
// top level of the 4x4 fixed-point matrix times vector transform
//
// channel   | handshake         | payload
// ----------+-------------------+-----------------------------------------
// command   | start, busy       | command, point_mode, in_x..in_w
// result    | done (strobe)     | out_x, out_y, out_z, out_w, clipped
// config    | cfg_we            | cfg_index, cfg_data
//
// one word accepted per cycle; each result is strobed on done once it has passed
// through the input register, multiply stage, two-level adder tree
// (second level with saturation) and merge register
// busy never rises: the pipeline has no feedback and no stall point
// the receiver cannot stall; done is high for one cycle per word
// reset loads the identity matrix and empties the pipeline
module vertex_transform_4x4_core #(
	parameter int DIM       = vt4_pkg::DEF_DIM,
	parameter int FRAC_BITS = vt4_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic                                point_mode,
	input  vt4_pkg::fx_t                        in_x,
	input  vt4_pkg::fx_t                        in_y,
	input  vt4_pkg::fx_t                        in_z,
	input  vt4_pkg::fx_t                        in_w,
	// matrix write port
	input  logic                                cfg_we,
	input  logic [vt4_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [vt4_pkg::MAT_W-1:0]           cfg_data,
	// result channel
	output logic                                done,
	output vt4_pkg::fx_t                        out_x,
	output vt4_pkg::fx_t                        out_y,
	output vt4_pkg::fx_t                        out_z,
	output vt4_pkg::fx_t                        out_w,
	output logic                                clipped
);
	import vt4_pkg::*;

	// 1.0 in the chosen fixed-point format, forced into the last component
	localparam fx_t ONE_FX = fx_t'(1 << FRAC_BITS);

	logic [MAT_W-1:0] cfg_q [NUM_REGS];

	logic      accept;
	fx_t       in_vec   [NUM_COMP];
	fx_t       vec_s1   [NUM_COMP];
	logic      cmd_s1;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;

	// unpacked matrix view and the per-lane operand selection
	fx_t       mat      [NUM_COMP][NUM_COMP];
	fx_t       lane_mat [NUM_COMP][NUM_COMP];
	lane_res_t lane_res [NUM_COMP];

	// the pipeline never holds off a word
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// matrix registers, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// element [r][c]: register 2r holds columns 0/1, 2r+1 holds columns 2/3
	for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
		for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
			if (c % 2 == 1) begin : g_hi
				assign mat[r][c] = cfg_q[2 * r + c / 2][MAT_W-1:XLEN];
			end else begin : g_lo
				assign mat[r][c] = cfg_q[2 * r + c / 2][XLEN-1:0];
			end
		end
	end

	// lane i takes row i for M*v, column i for the transpose
	for (genvar i = 0; i < NUM_COMP; i++) begin : g_sel_i
		for (genvar k = 0; k < NUM_COMP; k++) begin : g_sel_k
			assign lane_mat[i][k] = (cmd_s1 == CMD_MUL_T) ? mat[k][i] : mat[i][k];
		end
	end

	assign in_vec[0] = in_x;
	assign in_vec[1] = in_y;
	assign in_vec[2] = in_z;
	assign in_vec[3] = in_w;

	// input stage: capture vector, apply point mode
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_COMP; k++) begin
			vec_s1[k] <= (point_mode && (k == DIM - 1)) ? ONE_FX : in_vec[k];
		end
		cmd_s1 <= command;
	end

	// valid travels alongside the payload stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// one lane per output component; unused components read as zero
	for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
		if (i < DIM) begin : g_on
			vt4_lane #(
				.DIM       (DIM),
				.FRAC_BITS (FRAC_BITS)
			) u_lane (
				.clk    (clk),
				.mat_s1 (lane_mat[i]),
				.vec_s1 (vec_s1),
				.res_s4 (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = '0;
		end
	end

	// merge: or of the lane clip flags, output register and strobe
	vt4_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.res_s4   (lane_res),
		.done     (done),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.out_w    (out_w),
		.clipped  (clipped)
	);

	// every accepted word comes out as a done strobe
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted word did not produce a result");

	// no result without an earlier accepted word
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result strobe without a matching accepted word");

	// a clipped result has at least one component pinned to a bound
	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |->
			(out_x == {1'b0, {(XLEN-1){1'b1}}} || out_x == {1'b1, {(XLEN-1){1'b0}}} ||
			 out_y == {1'b0, {(XLEN-1){1'b1}}} || out_y == {1'b1, {(XLEN-1){1'b0}}} ||
			 out_z == {1'b0, {(XLEN-1){1'b1}}} || out_z == {1'b1, {(XLEN-1){1'b0}}} ||
			 out_w == {1'b0, {(XLEN-1){1'b1}}} || out_w == {1'b1, {(XLEN-1){1'b0}}}))
		else $error("clip flag set but no component saturated");

endmodule

// ----- tb/sv/vertex_transform_4x4_core_tb.sv -----
// self-checking testbench for the 4x4 fixed-point vertex transform core
module vertex_transform_4x4_core_tb;
	import vt4_pkg::*;

	// the block runs with its default shape, the predictor follows it
	localparam int DIM       = DEF_DIM;
	localparam int FRAC_BITS = DEF_FRAC_BITS;

	localparam int IDLE_PCT    = 21;     // sender idles this often, in percent
	localparam int DRAIN_QUIET = 8;      // quiet cycles before a matrix write
	localparam int END_QUIET   = 16;     // quiet cycles before the verdict
	localparam int CYCLE_LIMIT = 100000;

	localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
	localparam fx_t FX_MIN = 32'sh8000_0000;
	localparam fx_t FX_ONE = fx_t'(1) <<< FRAC_BITS;

	localparam logic signed [ACC_W-1:0] LANE_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] LANE_MIN = ACC_W'(-64'sd2147483648);

	// matrix register map, two packed Q16.16 entries per register
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROW0_C01, REG_ROW0_C23,
		REG_ROW1_C01, REG_ROW1_C23,
		REG_ROW2_C01, REG_ROW2_C23,
		REG_ROW3_C01, REG_ROW3_C23
	} mat_reg_e;

	// what the driver queue holds: a vector word, a matrix write, or a pause
	typedef enum logic [1:0] {WORD_VEC, WORD_CFG, WORD_DRAIN} word_kind_e;

	typedef struct {
		word_kind_e             kind;
		logic                   gap_ok;
		logic                   cmd;
		logic                   pt;
		fx_t                    x;
		fx_t                    y;
		fx_t                    z;
		fx_t                    w;
		logic [REG_IDX_W-1:0]   idx;
		logic [MAT_W-1:0]       data;
	} stim_word_t;

	typedef struct {
		fx_t  x;
		fx_t  y;
		fx_t  z;
		fx_t  w;
		logic clip;
	} xform_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 command = CMD_MUL;
	logic                 point_mode = 1'b0;
	fx_t                  in_x = '0;
	fx_t                  in_y = '0;
	fx_t                  in_z = '0;
	fx_t                  in_w = '0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [MAT_W-1:0]     cfg_data = '0;
	logic                 done;
	fx_t                  out_x;
	fx_t                  out_y;
	fx_t                  out_z;
	fx_t                  out_w;
	logic                 clipped;

	// predictor copy of the matrix registers
	logic [MAT_W-1:0] matrix_model [NUM_REGS];

	stim_word_t vertex_words [$];      // words still to be sent
	xform_res_t expected_xforms [$];   // predicted results, oldest first
	stim_word_t cur_word;              // word now on the input ports
	int         quiet_cycles = 0;
	int         fail_count = 0;
	int         cycle_cnt = 0;

	vertex_transform_4x4_core #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.point_mode (point_mode),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.in_w       (in_w),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.clipped    (clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// matrix entry m[r][c], sign extended to product width
	function automatic logic signed [PROD_W-1:0] matrix_elem(input int r, input int c);
		logic [MAT_W-1:0] packed_pair;
		fx_t              e;
		packed_pair = matrix_model[r * 2 + c / 2];
		e = packed_pair[(c % 2) * XLEN +: XLEN];
		return PROD_W'(e);
	endfunction

	// exact sum of products, floor shift, then clamp to 32 bits per lane
	function automatic xform_res_t transform_vertex(input stim_word_t wd);
		logic signed [PROD_W-1:0] vec [NUM_COMP];
		logic signed [PROD_W-1:0] m;
		logic signed [PROD_W-1:0] prod;
		logic signed [ACC_W-1:0]  acc;
		fx_t                      lane [NUM_COMP];
		logic                     any_clip;
		xform_res_t               r;
		vec[0] = PROD_W'(wd.x);
		vec[1] = PROD_W'(wd.y);
		vec[2] = PROD_W'(wd.z);
		vec[3] = PROD_W'(wd.w);
		// point mode forces the last live component to 1.0
		if (wd.pt)
			vec[DIM - 1] = PROD_W'(FX_ONE);
		any_clip = 1'b0;
		for (int i = 0; i < NUM_COMP; i++) begin
			lane[i] = '0;
			if (i < DIM) begin
				acc = '0;
				for (int k = 0; k < DIM; k++) begin
					m = (wd.cmd == CMD_MUL_T) ? matrix_elem(k, i) : matrix_elem(i, k);
					prod = m * vec[k];
					acc = acc + ACC_W'(prod);
				end
				acc = acc >>> FRAC_BITS;
				if (acc > LANE_MAX) begin
					lane[i] = FX_MAX;
					any_clip = 1'b1;
				end else if (acc < LANE_MIN) begin
					lane[i] = FX_MIN;
					any_clip = 1'b1;
				end else begin
					lane[i] = acc[XLEN-1:0];
				end
			end
		end
		r.x = lane[0];
		r.y = lane[1];
		r.z = lane[2];
		r.w = lane[3];
		r.clip = any_clip;
		return r;
	endfunction

	// vector component: mostly full range, some small, some edge values
	function automatic fx_t rand_comp();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return fx_t'($urandom);
			5, 6, 7: return fx_t'($urandom_range(32'h0200_0000) - 32'h0100_0000);
			default: begin
				case ($urandom_range(4))
					0: return FX_MAX;
					1: return FX_MIN;
					2: return '0;
					3: return '1;
					default: return FX_ONE;
				endcase
			end
		endcase
	endfunction

	// matrix entry: style 0 full range, 1 within +-4.0, 2 a mix with edge values
	function automatic fx_t rand_entry(input int style);
		case (style)
			0: return fx_t'($urandom);
			1: return fx_t'($urandom_range(32'h0008_0000) - 32'h0004_0000);
			default: begin
				case ($urandom_range(5))
					0: return FX_MAX;
					1: return FX_MIN;
					2: return fx_t'($urandom);
					default: return fx_t'($urandom_range(32'h0008_0000) - 32'h0004_0000);
				endcase
			end
		endcase
	endfunction

	task automatic add_vec(input logic cmd, input logic pt, input fx_t x, input fx_t y,
			input fx_t z, input fx_t w, input logic gap_ok);
		stim_word_t wd;
		wd.kind = WORD_VEC;
		wd.gap_ok = gap_ok;
		wd.cmd = cmd;
		wd.pt = pt;
		wd.x = x;
		wd.y = y;
		wd.z = z;
		wd.w = w;
		wd.idx = '0;
		wd.data = '0;
		vertex_words.push_back(wd);
	endtask

	// wait for the pipeline to empty, then load all eight registers
	task automatic add_matrix(input logic [MAT_W-1:0] mat [NUM_REGS]);
		stim_word_t wd;
		wd.gap_ok = 1'b1;
		wd.cmd = CMD_MUL;
		wd.pt = 1'b0;
		wd.x = '0;
		wd.y = '0;
		wd.z = '0;
		wd.w = '0;
		wd.idx = '0;
		wd.data = '0;
		wd.kind = WORD_DRAIN;
		vertex_words.push_back(wd);
		wd.kind = WORD_CFG;
		for (int i = 0; i < NUM_REGS; i++) begin
			wd.idx = mat_reg_e'(i);
			wd.data = mat[i];
			vertex_words.push_back(wd);
		end
	endtask

	task automatic check_field(input string name, input logic [XLEN-1:0] want,
			input logic [XLEN-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// driver: one word per accepted start, matrix writes only while idle
	always @(posedge clk) begin : drive
		logic nx_start;
		logic nx_we;
		if (arst_n) begin
			// bookkeeping for what this edge took in
			if (cfg_we)
				matrix_model[cfg_index] = cfg_data;
			if (start && !busy)
				expected_xforms.push_back(transform_vertex(cur_word));
			// a word that was not taken stays up
			nx_start = start && busy;
			nx_we = 1'b0;
			if (!nx_start && vertex_words.size() != 0) begin
				case (vertex_words[0].kind)
					WORD_VEC: begin
						// random idle cycles, except inside the burst stretch
						if (!vertex_words[0].gap_ok || $urandom_range(99) >= IDLE_PCT) begin
							cur_word = vertex_words.pop_front();
							nx_start = 1'b1;
							command <= cur_word.cmd;
							point_mode <= cur_word.pt;
							in_x <= cur_word.x;
							in_y <= cur_word.y;
							in_z <= cur_word.z;
							in_w <= cur_word.w;
						end
					end
					WORD_CFG: begin
						nx_we = 1'b1;
						cfg_index <= vertex_words[0].idx;
						cfg_data <= vertex_words[0].data;
						vertex_words.delete(0);
					end
					default: begin
						// pause until every result is back, then a few quiet cycles
						if (expected_xforms.size() != 0 || start)
							quiet_cycles = 0;
						else if (quiet_cycles >= DRAIN_QUIET) begin
							quiet_cycles = 0;
							vertex_words.delete(0);
						end else
							quiet_cycles++;
					end
				endcase
			end
			start <= nx_start;
			cfg_we <= nx_we;
		end
	end

	// monitor: every done strobe is checked against the oldest prediction
	always @(posedge clk) begin : watch
		xform_res_t want;
		if (arst_n && done) begin
			if (expected_xforms.size() == 0) begin
				fail_count++;
				$display("%0t: result with no word pending, expected none, actual %h %h %h %h %b",
					$time, out_x, out_y, out_z, out_w, clipped);
			end else begin
				want = expected_xforms.pop_front();
				check_field("out_x", want.x, out_x);
				check_field("out_y", want.y, out_y);
				check_field("out_z", want.z, out_z);
				check_field("out_w", want.w, out_w);
				check_field("clipped", {{(XLEN-1){1'b0}}, want.clip}, {{(XLEN-1){1'b0}}, clipped});
			end
		end
	end

	// run limit, far above the slowest legal run
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [MAT_W-1:0] mat [NUM_REGS];
		fx_t              e;

		// predictor starts from the identity, as the block does after reset
		for (int i = 0; i < NUM_REGS; i++)
			matrix_model[i] = '0;
		for (int r = 0; r < NUM_COMP; r++)
			matrix_model[r * 2 + r / 2][(r % 2) * XLEN +: XLEN] = FX_ONE;

		// identity matrix from reset: field extremes, both commands, point mode
		add_vec(CMD_MUL,   1'b0, '0, '0, '0, '0, 1'b1);
		add_vec(CMD_MUL,   1'b0, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1);
		add_vec(CMD_MUL,   1'b0, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1);
		add_vec(CMD_MUL_T, 1'b0, FX_MAX, FX_MIN, '1, FX_ONE, 1'b1);
		add_vec(CMD_MUL,   1'b1, FX_MIN, FX_MAX, '1, FX_MIN, 1'b1);
		add_vec(CMD_MUL_T, 1'b1, '1, '0, FX_MAX, FX_MAX, 1'b1);

		// all entries at the positive bound: lanes clip both ways
		for (int i = 0; i < NUM_REGS; i++)
			mat[i] = {FX_MAX, FX_MAX};
		add_matrix(mat);
		add_vec(CMD_MUL,   1'b0, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1);
		add_vec(CMD_MUL,   1'b0, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1);
		add_vec(CMD_MUL_T, 1'b1, FX_MIN, FX_MAX, FX_MIN, '0, 1'b1);
		add_vec(CMD_MUL,   1'b0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b1);

		// all entries at the negative bound: min times min must clip high
		for (int i = 0; i < NUM_REGS; i++)
			mat[i] = {FX_MIN, FX_MIN};
		add_matrix(mat);
		add_vec(CMD_MUL,   1'b0, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1);
		add_vec(CMD_MUL_T, 1'b0, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1);
		add_vec(CMD_MUL,   1'b0, '1, '1, '1, '1, 1'b1);

		// entries of minus one lsb: tiny negative sums floor toward minus infinity
		for (int i = 0; i < NUM_REGS; i++)
			mat[i] = '1;
		add_matrix(mat);
		add_vec(CMD_MUL,   1'b0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b1);
		add_vec(CMD_MUL,   1'b0, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1);
		add_vec(CMD_MUL_T, 1'b1, 32'sd1, '1, FX_MIN, 32'sd3, 1'b1);

		// distinct signed entries so that the transpose differs from the plain product
		for (int i = 0; i < NUM_REGS; i++)
			mat[i] = '0;
		for (int r = 0; r < NUM_COMP; r++) begin
			for (int c = 0; c < NUM_COMP; c++) begin
				e = fx_t'((r * 4 + c + 1) <<< FRAC_BITS) + fx_t'(32'h1234);
				if ((r + c) % 2 == 1)
					e = -e;
				mat[r * 2 + c / 2][(c % 2) * XLEN +: XLEN] = e;
			end
		end
		add_matrix(mat);
		add_vec(CMD_MUL,   1'b0, FX_ONE, 2 * FX_ONE, 3 * FX_ONE, 4 * FX_ONE, 1'b1);
		add_vec(CMD_MUL_T, 1'b0, FX_ONE, 2 * FX_ONE, 3 * FX_ONE, 4 * FX_ONE, 1'b1);
		add_vec(CMD_MUL,   1'b1, -32'sd3, 32'sd5, -32'sh0001_8001, 32'sd7, 1'b1);
		add_vec(CMD_MUL_T, 1'b1, -32'sd3, 32'sd5, -32'sh0001_8001, FX_MIN, 1'b1);

		// random phases, each with a fresh matrix; one phase holds a no-idle burst
		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < NUM_REGS; i++)
				mat[i] = {rand_entry(ph % 3), rand_entry(ph % 3)};
			add_matrix(mat);
			for (int n = 0; n < 85; n++)
				add_vec(1'($urandom_range(1)), 1'($urandom_range(1)), rand_comp(),
					rand_comp(), rand_comp(), rand_comp(),
					!(ph == 3 && n >= 10 && n < 70));
		end

		// reset held at the start, released once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last word to go and every result to come back
		do
			@(posedge clk);
		while (vertex_words.size() != 0 || start || expected_xforms.size() != 0);
		repeat (END_QUIET) @(posedge clk);

		if (expected_xforms.size() != 0) begin
			fail_count++;
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, expected_xforms.size());
		end

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
